// File: design/ppd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and decode tables for the poll packet event decoder.
// Depends on nothing; every other file of the block imports it.
package ppd_pkg;

    // Poll byte that opens a packet; the host answers the ack word with 0xC3.
    localparam logic [7:0] POLL_BYTE = 8'h5A;

    // Result kinds carried on tuser.
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // Controller states: the four parse phases plus the unit emission run.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SIZE,
        S_MASK,
        S_DATA,
        S_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ack;        // poll word accepted, load the ack result
        logic load_size;  // valid size word accepted
        logic load_mask;  // function mask word accepted
        logic data_step;  // data word accepted (address or function)
        logic emit_load;  // load the next buffered unit into the output
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_poll;     // input word is the poll byte
        logic size_ok;     // input word is a legal packet size
        logic fn_byte;     // current mask bit marks a function word
        logic fn_units;    // a function word now would emit buffered units
        logic bytes_last;  // the current data word ends the packet
        logic bytes_zero;  // no data words remain
        logic emit_last;   // the unit being emitted is the final one
        logic out_free;    // output register can take a result this cycle
    } t_stat;

    // Address code to unit number 1..16.
    function automatic logic [4:0] unit_of_code(input logic [3:0] code);
        logic [4:0] u;
        case (code)
            4'h0: u = 5'd13;
            4'h1: u = 5'd5;
            4'h2: u = 5'd3;
            4'h3: u = 5'd11;
            4'h4: u = 5'd15;
            4'h5: u = 5'd7;
            4'h6: u = 5'd1;
            4'h7: u = 5'd9;
            4'h8: u = 5'd14;
            4'h9: u = 5'd6;
            4'hA: u = 5'd4;
            4'hB: u = 5'd12;
            4'hC: u = 5'd16;
            4'hD: u = 5'd8;
            4'hE: u = 5'd2;
            default: u = 5'd10;
        endcase
        return u;
    endfunction

    // House code to letter index, A = 0 through P = 15 (order MECKOGAINFDLPHBJ).
    function automatic logic [3:0] letter_of_house(input logic [3:0] code);
        logic [3:0] l;
        case (code)
            4'h0: l = 4'd12;
            4'h1: l = 4'd4;
            4'h2: l = 4'd2;
            4'h3: l = 4'd10;
            4'h4: l = 4'd14;
            4'h5: l = 4'd6;
            4'h6: l = 4'd0;
            4'h7: l = 4'd8;
            4'h8: l = 4'd13;
            4'h9: l = 4'd5;
            4'hA: l = 4'd3;
            4'hB: l = 4'd11;
            4'hC: l = 4'd15;
            4'hD: l = 4'd7;
            4'hE: l = 4'd1;
            default: l = 4'd9;
        endcase
        return l;
    endfunction

endpackage

// File: design/ppd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the poll packet event decoder.
// Depends on ppd_pkg for the state type and the command and status structs.
module ppd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  ppd_pkg::t_stat i_stat,
    output ppd_pkg::t_cmd  o_cmd
);
    import ppd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   s_ready;
    logic   s_acc;

    // Input words are taken in every parse phase while the output can absorb a result.
    assign s_ready         = (r_state != S_EMIT) && i_stat.out_free;
    assign s_acc           = i_s_axis_tvalid && s_ready;
    assign o_s_axis_tready = s_ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_acc && i_stat.is_poll) n_state = S_SIZE;
            end
            S_SIZE: begin
                if (s_acc) n_state = i_stat.size_ok ? S_MASK : S_IDLE;
            end
            S_MASK: begin
                if (s_acc) n_state = S_DATA;
            end
            S_DATA: begin
                if (s_acc) begin
                    if (i_stat.fn_byte && i_stat.fn_units) begin
                        n_state = S_EMIT;
                    end else if (i_stat.bytes_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free && i_stat.emit_last) begin
                    n_state = i_stat.bytes_zero ? S_IDLE : S_DATA;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.ack       = s_acc && (r_state == S_IDLE) && i_stat.is_poll;
        o_cmd.load_size = s_acc && (r_state == S_SIZE) && i_stat.size_ok;
        o_cmd.load_mask = s_acc && (r_state == S_MASK);
        o_cmd.data_step = s_acc && (r_state == S_DATA);
        o_cmd.emit_load = (r_state == S_EMIT) && i_stat.out_free;
    end

`ifndef SYNTH
    // A function word with buffered units always leads into the emission run.
    a_fn_to_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.data_step && i_stat.fn_byte && i_stat.fn_units) |=> (r_state == S_EMIT))
        else $error("function word with units did not start emission");
`endif

endmodule

// File: design/ppd_dp.sv
`timescale 1ns / 1ps
// Datapath of the poll packet event decoder: packet counters, unit buffer,
// emission index and output register. Depends on ppd_pkg.
module ppd_dp #(
    parameter int UNIT_DEPTH     = 16,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_out_ready,
    input  ppd_pkg::t_cmd  i_cmd,
    output ppd_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic           o_result_kind,
    output logic [3:0]     o_house_letter,
    output logic [3:0]     o_function_code,
    output logic           o_unit_present,
    output logic [4:0]     o_unit_number,
    output logic           o_last_of_run
);
    import ppd_pkg::*;

    localparam int         CW       = $clog2(UNIT_DEPTH + 1);
    localparam int         IW       = (UNIT_DEPTH > 1) ? $clog2(UNIT_DEPTH) : 1;
    localparam logic [7:0] SIZE_MAX = 8'(MAX_DATA_BYTES + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(UNIT_DEPTH);

    // Packet state.
    logic [3:0]    r_bytes_left;
    logic [7:0]    r_mask;
    logic [3:0]    r_house;
    logic [CW-1:0] r_count;

    // Emission run state.
    logic [CW-1:0] r_emit_n;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [3:0]    r_fn;
    logic [3:0]    r_letter;

    // Unit buffer.
    logic [3:0]    r_units [UNIT_DEPTH];
    logic [3:0]    r_rdata;

    // Output register.
    logic          r_out_valid;
    logic          r_out_kind;
    logic [3:0]    r_out_house;
    logic [3:0]    r_out_fn;
    logic          r_out_present;
    logic [4:0]    r_out_unit;
    logic          r_out_last;

    logic [3:0]    hi;
    logic [3:0]    lo;
    logic          house_match;
    logic [3:0]    cur_letter;
    logic          out_free;
    logic          emit_last;
    logic          is_addr;
    logic          addr_restart;
    logic          addr_store;
    logic          fn_single;

    assign hi          = i_rx_byte[7:4];
    assign lo          = i_rx_byte[3:0];
    assign house_match = (hi == r_house);
    assign cur_letter  = letter_of_house(r_house);
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit_last   = ((CW'(r_idx) + CW'(1)) == r_emit_n);
    assign is_addr     = i_cmd.data_step && !r_mask[0];
    assign fn_single   = i_cmd.data_step && r_mask[0] && !(house_match && (r_count != '0));

    // An address word restarts the buffer on an empty buffer or a new house code.
    assign addr_restart = (r_count == '0) || !house_match;
    assign addr_store   = is_addr && (addr_restart || (r_count < DEPTH_C));

    // Status to the controller.
    always_comb begin
        o_stat            = '0;
        o_stat.is_poll    = (i_rx_byte == POLL_BYTE);
        o_stat.size_ok    = (i_rx_byte >= 8'd2) && (i_rx_byte <= SIZE_MAX);
        o_stat.fn_byte    = r_mask[0];
        o_stat.fn_units   = house_match && (r_count != '0);
        o_stat.bytes_last = (r_bytes_left <= 4'd1);
        o_stat.bytes_zero = (r_bytes_left == 4'd0);
        o_stat.emit_last  = emit_last;
        o_stat.out_free   = out_free;
    end

    // Packet counters, mask and house code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_mask       <= '0;
            r_house      <= '0;
            r_count      <= '0;
        end else begin
            if (i_cmd.load_size) r_bytes_left <= 4'(i_rx_byte - 8'd1);
            if (i_cmd.load_mask) r_mask <= i_rx_byte;
            if (i_cmd.data_step) begin
                r_mask <= {1'b0, r_mask[7:1]};
                if (r_bytes_left != 4'd0) r_bytes_left <= r_bytes_left - 4'd1;
                if (r_mask[0]) begin
                    r_count <= '0;
                end else if (addr_restart) begin
                    r_house <= hi;
                    r_count <= CW'(1);
                end else if (addr_store) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

    // Emission run: latch the function word and walk the buffer.
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.data_step) begin
            n_idx = '0;
        end else if (i_cmd.emit_load) begin
            n_idx = emit_last ? '0 : r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.data_step && r_mask[0]) begin
            r_emit_n <= r_count;
            r_fn     <= lo;
            r_letter <= cur_letter;
        end
    end

    // Unit buffer: one write port, registered read that follows the next index.
    always_ff @(posedge i_clk) begin
        if (addr_store) begin
            r_units[addr_restart ? IW'(0) : r_count[IW-1:0]] <= lo;
        end
        r_rdata <= r_units[n_idx];
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ack || fn_single || i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ack) begin
            r_out_kind    <= KIND_ACK;
            r_out_house   <= '0;
            r_out_fn      <= '0;
            r_out_present <= 1'b0;
            r_out_unit    <= '0;
            r_out_last    <= 1'b1;
        end else if (fn_single) begin
            r_out_kind    <= KIND_EVENT;
            r_out_house   <= cur_letter;
            r_out_fn      <= lo;
            r_out_present <= 1'b0;
            r_out_unit    <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_out_kind    <= KIND_EVENT;
            r_out_house   <= r_letter;
            r_out_fn      <= r_fn;
            r_out_present <= 1'b1;
            r_out_unit    <= unit_of_code(r_rdata);
            r_out_last    <= emit_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_house_letter  = r_out_house;
    assign o_function_code = r_out_fn;
    assign o_unit_present  = r_out_present;
    assign o_unit_number   = r_out_unit;
    assign o_last_of_run   = r_out_last;

`ifndef SYNTH
    // The buffer fill never passes its depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("unit buffer count beyond depth");

    // The data word count stays within the packet limit.
    a_bytes_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= 4'(MAX_DATA_BYTES))
        else $error("data word count beyond packet limit");

    // An ack word is always a single-word run.
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == KIND_ACK)) |-> (r_out_last && !r_out_present))
        else $error("ack word without last or with a unit");
`endif

endmodule

// File: design/poll_packet_event_decoder_core.sv
`timescale 1ns / 1ps
// Poll packet event decoder, top level.
// Joins the controller (ppd_ctrl) and the datapath (ppd_dp); uses ppd_pkg.
//
// Usage: received interface bytes enter on the slave stream, one byte per word
// in tdata. In idle a poll byte 0x5A yields an ack word (tuser = 0): the host
// must send 0xC3. A size byte, a function mask byte and size-1 data bytes
// follow; address bytes are buffered per house code, and a function byte
// yields one event word per buffered unit, or a single event word without a
// unit. tlast marks the final word caused by one input byte.
// Output: an ack word or an event word without a unit is presented in the
// cycle after the byte is accepted; the first unit word of a run is loaded in
// the emission state, once the registered buffer read has returned its entry.
// Throughput, while the output is free: one input byte per cycle outside a
// unit run; a function byte with buffered units holds the input for its run,
// one unit word per cycle, paced by the single read port of the unit buffer.
// Reset (synchronous, active low) returns to idle with an empty buffer and no
// word pending. When the receiver stalls, the output register holds its word
// and the input is not taken until that word can be replaced.
module poll_packet_event_decoder_core #(
    parameter int UNIT_DEPTH     = 16,
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [3:0] house_letter, [7:4] function_code,
                                          // [8] unit_present, [13:9] unit_number, [15:14] 0
    output logic        o_m_axis_tuser,   // [0] result_kind
    output logic        o_m_axis_tlast    // last_of_run
);
    import ppd_pkg::*;

    t_cmd       cmd;
    t_stat      stat;
    logic [3:0] house_letter;
    logic [3:0] function_code;
    logic       unit_present;
    logic [4:0] unit_number;

    ppd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    ppd_dp #(
        .UNIT_DEPTH     (UNIT_DEPTH),
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_byte       (i_s_axis_tdata),
        .i_out_ready     (i_m_axis_tready),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_m_axis_tvalid),
        .o_result_kind   (o_m_axis_tuser),
        .o_house_letter  (house_letter),
        .o_function_code (function_code),
        .o_unit_present  (unit_present),
        .o_unit_number   (unit_number),
        .o_last_of_run   (o_m_axis_tlast)
    );

    // Pack the result word, first field in the lowest bits.
    assign o_m_axis_tdata = {2'b00, unit_number, unit_present, function_code, house_letter};

endmodule
